// File: hw/rtl/tis_pkg.sv
// ----------------------------------------------------------------------------
// tis_pkg
// shared constants and crossing case codes for the isoline segment block
// ----------------------------------------------------------------------------
package tis_pkg;

    localparam int VALUE_BITS_DEF      = 24;
    localparam int COORD_BITS_DEF      = 24;
    localparam int ALPHA_FRAC_BITS_DEF = 16;
    localparam int CASE_BITS           = 3;
    localparam int MID_DEPTH_DEF       = 2;

    typedef enum logic [CASE_BITS-1:0] {
        CASE_NONE  = 3'd0,
        CASE_AB    = 3'd1,
        CASE_BC    = 3'd2,
        CASE_CA    = 3'd3,
        CASE_AB_BC = 3'd4,
        CASE_AB_CA = 3'd5,
        CASE_BC_CA = 3'd6
    } case_t;

endpackage

// File: hw/rtl/tis_fifo.sv
// ----------------------------------------------------------------------------
// tis_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module tis_fifo
    import tis_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hw/rtl/tis_front.sv
// ----------------------------------------------------------------------------
// tis_front
// classifies one triangle against the level and selects the edges to cut
// ----------------------------------------------------------------------------
module tis_front
    import tis_pkg::*;
#(
    parameter int VB = VALUE_BITS_DEF,
    parameter int CB = COORD_BITS_DEF,
    parameter int IW = CASE_BITS + 4 * VB + 6 * CB + 6 * (CB + 1)
)
(
    input  logic signed [VB-1:0] level,
    input  logic signed [VB-1:0] value_a,
    input  logic signed [VB-1:0] value_b,
    input  logic signed [VB-1:0] value_c,
    input  logic signed [CB-1:0] pos_a_x,
    input  logic signed [CB-1:0] pos_a_y,
    input  logic signed [CB-1:0] pos_a_z,
    input  logic signed [CB-1:0] pos_b_x,
    input  logic signed [CB-1:0] pos_b_y,
    input  logic signed [CB-1:0] pos_b_z,
    input  logic signed [CB-1:0] pos_c_x,
    input  logic signed [CB-1:0] pos_c_y,
    input  logic signed [CB-1:0] pos_c_z,
    output logic [IW-1:0]        item
);

    function automatic logic [VB-1:0] abs_diff(input logic signed [VB-1:0] x,
                                               input logic signed [VB-1:0] y);
        logic signed [VB:0] d;
        d = {x[VB-1], x} - {y[VB-1], y};
        return d[VB] ? VB'(-d) : d[VB-1:0];
    endfunction

    logic signed [VB-1:0] f [3];
    logic signed [CB-1:0] pos [3][3];
    logic [2:0]           on;
    logic [2:0]           cr;
    case_t                cs;
    logic                 cut;
    logic [1:0]           e0, n0, e1, n1;
    logic [VB-1:0]        num0, den0, num1, den1;
    logic signed [CB-1:0] p0 [3];
    logic signed [CB-1:0] p1 [3];
    logic signed [CB:0]   d0 [3];
    logic signed [CB:0]   d1 [3];

    assign f[0] = value_a;
    assign f[1] = value_b;
    assign f[2] = value_c;
    assign pos[0][0] = pos_a_x;
    assign pos[0][1] = pos_a_y;
    assign pos[0][2] = pos_a_z;
    assign pos[1][0] = pos_b_x;
    assign pos[1][1] = pos_b_y;
    assign pos[1][2] = pos_b_z;
    assign pos[2][0] = pos_c_x;
    assign pos[2][1] = pos_c_y;
    assign pos[2][2] = pos_c_z;

    for (genvar i = 0; i < 3; i++)
    begin : g_edge
        assign on[i] = (f[i] == level);
        assign cr[i] = ((f[i] < level) && (level < f[(i + 1) % 3])) ||
                       ((f[(i + 1) % 3] < level) && (level < f[i]));
    end

    // first matching rule wins
    always_comb
    begin
        priority if (on[0] && on[1]) cs = CASE_AB;
        else if (on[1] && on[2])     cs = CASE_BC;
        else if (on[2] && on[0])     cs = CASE_CA;
        else if (cr[0] && cr[1])     cs = CASE_AB_BC;
        else if (cr[0] && cr[2])     cs = CASE_AB_CA;
        else if (cr[1] && cr[2])     cs = CASE_BC_CA;
        else                         cs = CASE_NONE;
    end

    always_comb
    begin
        cut  = 1'b0;
        e0   = 2'd0;
        n0   = 2'd1;
        e1   = 2'd1;
        n1   = 2'd2;
        num0 = '0;
        num1 = '0;
        den0 = VB'(1);
        den1 = VB'(1);
        for (int j = 0; j < 3; j++)
        begin
            p0[j] = '0;
            p1[j] = '0;
            d0[j] = '0;
            d1[j] = '0;
        end
        unique case (cs)
            CASE_AB:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    p0[j] = pos[0][j];
                    p1[j] = pos[1][j];
                end
            end
            CASE_BC:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    p0[j] = pos[1][j];
                    p1[j] = pos[2][j];
                end
            end
            CASE_CA:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    p0[j] = pos[2][j];
                    p1[j] = pos[0][j];
                end
            end
            CASE_AB_BC:
            begin
                cut = 1'b1;
            end
            CASE_AB_CA:
            begin
                cut = 1'b1;
                e1  = 2'd2;
                n1  = 2'd0;
            end
            CASE_BC_CA:
            begin
                cut = 1'b1;
                e0  = 2'd1;
                n0  = 2'd2;
                e1  = 2'd2;
                n1  = 2'd0;
            end
            default:
            begin
                cut = 1'b0;
            end
        endcase
        if (cut)
        begin
            num0 = abs_diff(level, f[e0]);
            den0 = abs_diff(f[n0], f[e0]);
            num1 = abs_diff(level, f[e1]);
            den1 = abs_diff(f[n1], f[e1]);
            for (int j = 0; j < 3; j++)
            begin
                p0[j] = pos[e0][j];
                p1[j] = pos[e1][j];
                d0[j] = {pos[n0][j][CB-1], pos[n0][j]} - {pos[e0][j][CB-1], pos[e0][j]};
                d1[j] = {pos[n1][j][CB-1], pos[n1][j]} - {pos[e1][j][CB-1], pos[e1][j]};
            end
        end
    end

    assign item = {cs, num0, den0, num1, den1,
                   p0[0], p0[1], p0[2], d0[0], d0[1], d0[2],
                   p1[0], p1[1], p1[2], d1[0], d1[1], d1[2]};

endmodule

// File: hw/rtl/tis_back.sv
// ----------------------------------------------------------------------------
// tis_back
// pipelined alpha division, interpolation multiply and endpoint add
// ----------------------------------------------------------------------------
module tis_back
    import tis_pkg::*;
#(
    parameter int VB = VALUE_BITS_DEF,
    parameter int CB = COORD_BITS_DEF,
    parameter int FB = ALPHA_FRAC_BITS_DEF,
    parameter int IW = CASE_BITS + 4 * VB + 6 * CB + 6 * (CB + 1),
    parameter int OW = CASE_BITS + 6 * CB,
    parameter int CREDITS = FB + 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_avail,
    input  logic [IW-1:0] in_item,
    output logic          in_take,
    input  logic          out_freed,
    output logic          out_push,
    output logic [OW-1:0] out_word
);

    localparam int NS = FB + 1;
    localparam int PW = CB + FB + 2;
    localparam int KW = $clog2(CREDITS + 1);

    // unpacked view of the queue word
    logic [CASE_BITS-1:0] i_cs;
    logic [VB-1:0]        i_num0, i_den0, i_num1, i_den1;
    logic signed [CB-1:0] i_p0 [3];
    logic signed [CB-1:0] i_p1 [3];
    logic signed [CB:0]   i_d0 [3];
    logic signed [CB:0]   i_d1 [3];

    assign {i_cs, i_num0, i_den0, i_num1, i_den1,
            i_p0[0], i_p0[1], i_p0[2], i_d0[0], i_d0[1], i_d0[2],
            i_p1[0], i_p1[1], i_p1[2], i_d1[0], i_d1[1], i_d1[2]} = in_item;

    // credits cover words in flight plus words in the result queue
    logic [KW-1:0] used_reg, used_next;

    assign in_take = in_avail && (used_reg < KW'(CREDITS));

    always_comb
    begin
        used_next = used_reg;
        if (in_take && !out_freed)
        begin
            used_next = used_reg + 1'b1;
        end
        else if (out_freed && !in_take)
        begin
            used_next = used_reg - 1'b1;
        end
    end

    // divider stages: stage 0 is the load, each later stage retires one quotient bit
    logic                 vld_reg  [NS];
    logic [CASE_BITS-1:0] cs_reg   [NS];
    logic [VB-1:0]        r0_reg   [NS];
    logic [VB-1:0]        r1_reg   [NS];
    logic [VB-1:0]        den0_reg [NS];
    logic [VB-1:0]        den1_reg [NS];
    logic [FB-1:0]        q0_reg   [NS];
    logic [FB-1:0]        q1_reg   [NS];
    logic signed [CB-1:0] p0_reg   [NS][3];
    logic signed [CB-1:0] p1_reg   [NS][3];
    logic signed [CB:0]   d0_reg   [NS][3];
    logic signed [CB:0]   d1_reg   [NS][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            for (int s = 0; s < NS; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            used_reg   <= used_next;
            vld_reg[0] <= in_take;
            for (int s = 1; s < NS; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cs_reg[0]   <= i_cs;
        r0_reg[0]   <= i_num0;
        r1_reg[0]   <= i_num1;
        den0_reg[0] <= i_den0;
        den1_reg[0] <= i_den1;
        q0_reg[0]   <= '0;
        q1_reg[0]   <= '0;
        for (int j = 0; j < 3; j++)
        begin
            p0_reg[0][j] <= i_p0[j];
            p1_reg[0][j] <= i_p1[j];
            d0_reg[0][j] <= i_d0[j];
            d1_reg[0][j] <= i_d1[j];
        end
    end

    for (genvar s = 1; s < NS; s++)
    begin : g_div
        logic [VB:0]   sh0, sh1;
        logic          ge0, ge1;
        logic [VB-1:0] rn0, rn1;

        assign sh0 = {r0_reg[s-1], 1'b0};
        assign sh1 = {r1_reg[s-1], 1'b0};
        assign ge0 = (sh0 >= {1'b0, den0_reg[s-1]});
        assign ge1 = (sh1 >= {1'b0, den1_reg[s-1]});
        assign rn0 = ge0 ? VB'(sh0 - {1'b0, den0_reg[s-1]}) : sh0[VB-1:0];
        assign rn1 = ge1 ? VB'(sh1 - {1'b0, den1_reg[s-1]}) : sh1[VB-1:0];

        always_ff @(posedge clk)
        begin
            cs_reg[s]   <= cs_reg[s-1];
            r0_reg[s]   <= rn0;
            r1_reg[s]   <= rn1;
            den0_reg[s] <= den0_reg[s-1];
            den1_reg[s] <= den1_reg[s-1];
            q0_reg[s]   <= {q0_reg[s-1][FB-2:0], ge0};
            q1_reg[s]   <= {q1_reg[s-1][FB-2:0], ge1};
            for (int j = 0; j < 3; j++)
            begin
                p0_reg[s][j] <= p0_reg[s-1][j];
                p1_reg[s][j] <= p1_reg[s-1][j];
                d0_reg[s][j] <= d0_reg[s-1][j];
                d1_reg[s][j] <= d1_reg[s-1][j];
            end
        end
    end

    // multiply stage
    logic                 mul_vld_reg;
    logic [CASE_BITS-1:0] mul_cs_reg;
    logic signed [CB-1:0] mul_p0_reg [3];
    logic signed [CB-1:0] mul_p1_reg [3];
    logic signed [PW-1:0] prod0_reg  [3];
    logic signed [PW-1:0] prod1_reg  [3];
    logic signed [FB:0]   alpha0, alpha1;

    assign alpha0 = {1'b0, q0_reg[NS-1]};
    assign alpha1 = {1'b0, q1_reg[NS-1]};

    // add stage
    logic                 add_vld_reg;
    logic [CASE_BITS-1:0] add_cs_reg;
    logic [CB-1:0]        s_reg [3];
    logic [CB-1:0]        e_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            add_vld_reg <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= vld_reg[NS-1];
            add_vld_reg <= mul_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_cs_reg <= cs_reg[NS-1];
        add_cs_reg <= mul_cs_reg;
        for (int j = 0; j < 3; j++)
        begin
            mul_p0_reg[j] <= p0_reg[NS-1][j];
            mul_p1_reg[j] <= p1_reg[NS-1][j];
            prod0_reg[j]  <= d0_reg[NS-1][j] * alpha0;
            prod1_reg[j]  <= d1_reg[NS-1][j] * alpha1;
            // arithmetic shift of the product floors toward minus infinity
            s_reg[j] <= mul_p0_reg[j] + prod0_reg[j][FB+CB-1:FB];
            e_reg[j] <= mul_p1_reg[j] + prod1_reg[j][FB+CB-1:FB];
        end
    end

    assign out_push = add_vld_reg;
    assign out_word = {add_cs_reg, s_reg[0], s_reg[1], s_reg[2],
                       e_reg[0], e_reg[1], e_reg[2]};

endmodule

// File: hw/rtl/triangle_isoline_segment.sv
// ----------------------------------------------------------------------------
// triangle_isoline_segment
// marching-triangles isoline segment for one triangle per word
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  config    cfg_we              cfg_data (iso level)
//  input     push / full         value_a..c, pos_a_x..pos_c_z
//  result    pop / empty         crossing_case, start_x..z, end_x..z
//
//  one triangle a cycle sustained while results are popped; a word
//  reaches the result queue after it is taken from the middle queue and
//  passes the one-bit-per-stage alpha divider plus multiply and add stages
//  reset clears the queues, the pipeline valids and the level (to zero)
//  input and result sides stall on their own; the back end issues only
//  while the result queue has a free slot for every word in flight
// ----------------------------------------------------------------------------
module triangle_isoline_segment
    import tis_pkg::*;
#(
    parameter int VALUE_BITS      = VALUE_BITS_DEF,
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int ALPHA_FRAC_BITS = ALPHA_FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic signed [VALUE_BITS-1:0] cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic signed [VALUE_BITS-1:0] value_a,
    input  logic signed [VALUE_BITS-1:0] value_b,
    input  logic signed [VALUE_BITS-1:0] value_c,
    input  logic signed [COORD_BITS-1:0] pos_a_x,
    input  logic signed [COORD_BITS-1:0] pos_a_y,
    input  logic signed [COORD_BITS-1:0] pos_a_z,
    input  logic signed [COORD_BITS-1:0] pos_b_x,
    input  logic signed [COORD_BITS-1:0] pos_b_y,
    input  logic signed [COORD_BITS-1:0] pos_b_z,
    input  logic signed [COORD_BITS-1:0] pos_c_x,
    input  logic signed [COORD_BITS-1:0] pos_c_y,
    input  logic signed [COORD_BITS-1:0] pos_c_z,
    output logic                         empty,
    input  logic                         pop,
    output logic [CASE_BITS-1:0]         crossing_case,
    output logic signed [COORD_BITS-1:0] start_x,
    output logic signed [COORD_BITS-1:0] start_y,
    output logic signed [COORD_BITS-1:0] start_z,
    output logic signed [COORD_BITS-1:0] end_x,
    output logic signed [COORD_BITS-1:0] end_y,
    output logic signed [COORD_BITS-1:0] end_z
);

    // word layouts between the parts
    localparam int IW = CASE_BITS + 4 * VALUE_BITS + 6 * COORD_BITS + 6 * (COORD_BITS + 1);
    localparam int OW = CASE_BITS + 6 * COORD_BITS;
    // pipeline holds ALPHA_FRAC_BITS + 3 words; two more keep full rate under pop
    localparam int OUT_DEPTH = ALPHA_FRAC_BITS + 5;

    // iso level register; the user must see that it is written only while idle, the block does not enforce it
    logic signed [VALUE_BITS-1:0] level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else if (cfg_we)
        begin
            level_reg <= cfg_data;
        end
    end

    // front end: classify the triangle and pick the edges to cut
    logic [IW-1:0] front_word;

    tis_front #(
        .VB (VALUE_BITS),
        .CB (COORD_BITS),
        .IW (IW)
    ) u_front (
        .level   (level_reg),
        .value_a (value_a),
        .value_b (value_b),
        .value_c (value_c),
        .pos_a_x (pos_a_x),
        .pos_a_y (pos_a_y),
        .pos_a_z (pos_a_z),
        .pos_b_x (pos_b_x),
        .pos_b_y (pos_b_y),
        .pos_b_z (pos_b_z),
        .pos_c_x (pos_c_x),
        .pos_c_y (pos_c_y),
        .pos_c_z (pos_c_z),
        .item    (front_word)
    );

    // middle queue decouples the front end from the back end
    logic [IW-1:0] mid_word;
    logic          mid_empty;
    logic          mid_take;

    tis_fifo #(
        .WIDTH (IW),
        .DEPTH (MID_DEPTH_DEF)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_word),
        .full    (full),
        .pop     (mid_take),
        .rd_data (mid_word),
        .empty   (mid_empty)
    );

    // back end: divide, multiply, add
    logic          back_push;
    logic [OW-1:0] back_word;
    logic          res_freed;

    assign res_freed = pop && !empty;

    tis_back #(
        .VB      (VALUE_BITS),
        .CB      (COORD_BITS),
        .FB      (ALPHA_FRAC_BITS),
        .IW      (IW),
        .OW      (OW),
        .CREDITS (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_avail  (!mid_empty),
        .in_item   (mid_word),
        .in_take   (mid_take),
        .out_freed (res_freed),
        .out_push  (back_push),
        .out_word  (back_word)
    );

    // result queue; credits guarantee it never overflows
    logic [OW-1:0] res_word;
    logic          res_full;

    tis_fifo #(
        .WIDTH (OW),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (back_push),
        .wr_data (back_word),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_word),
        .empty   (empty)
    );

    logic res_unused;
    assign res_unused = res_full;

    assign {crossing_case, start_x, start_y, start_z, end_x, end_y, end_z} =
        res_unused ? res_word : res_word;

endmodule
